// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define DPW_ASSERT_NOW(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error("dpw assertion failed");

// Next-cycle implication, disabled while reset is active.
`define DPW_ASSERT_NEXT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("dpw assertion failed");

`endif

// ----- src/dpw_pkg.sv -----
`default_nettype none

package dpw_pkg;

  // Register indexes of the configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POSE_ROT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POSE_TRANS  = 3'd6;

  // Reset values
  localparam logic [15:0] RST_CENTER_X    = 16'd5208;
  localparam logic [15:0] RST_CENTER_Y    = 16'd4056;
  localparam logic [15:0] RST_FOCAL_X     = 16'd8288;
  localparam logic [15:0] RST_FOCAL_Y     = 16'd8304;
  localparam logic [15:0] RST_DEPTH_SCALE = 16'd1000;
  localparam logic [63:0] RST_POSE_ROT    = 64'h4000_0000_0000_0000;
  localparam logic [62:0] RST_POSE_TRANS  = 63'd0;

  // Divider geometry
  localparam int FRAC_W  = 16;           // fraction bits of Q15.16
  localparam int DIV_W   = 32;           // divisor and quotient bits
  localparam int NUM_W   = 49;           // rounded numerator bits
  localparam int DIV_LAT = DIV_W + 2;    // overflow stage, bit stages, saturate stage

  localparam int LANES     = 3;
  localparam int FRONT_LAT = 4;
  localparam int BACK_LAT  = 4;
  localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + BACK_LAT;

  typedef logic [NUM_W-1:0]        num_t;
  typedef logic [DIV_W-1:0]        divisor_t;
  typedef logic signed [31:0]      cam_t;
  typedef logic signed [30:0]      rot_t;

  localparam cam_t CAM_MAX = 32'sh7FFF_FFFF;
  localparam cam_t CAM_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic valid;
    logic neg;
  } div_ctl_t;

endpackage

`default_nettype wire

// ----- src/depth_pixel_to_world_point_core.sv -----
`default_nettype none
`include "assert_macros.svh"

// RGB-D pixel to world point. A word is taken on every clock edge at which
// start is high (busy is always low, the pipeline never stalls), so one
// pixel per cycle streams through. A pixel with nonzero depth comes out
// at the end of the pipeline as a one-cycle out_valid strobe with world x, y,
// z in signed Q15.16 metres (saturated) and the colour as red, green, blue;
// a pixel with zero depth is dropped and leaves no strobe. Order is kept.
// The receiver cannot hold results off, so it must take every strobe. The
// latency is set by the three camera-coordinate dividers, each a 34-stage
// pipeline with one quotient bit per bit stage; four stages in front form
// numerators and four behind apply the rotation and translation. Pixels in
// flight read the configuration registers live, so write configuration only
// while no pixel is in the pipeline. Zero focal length or depth scale counts
// as one; the quaternion is used as written, not normalized.
module depth_pixel_to_world_point_core (
  input  wire                             clk,
  input  wire                             rst_n,
  // pixel input
  input  wire                             start,
  output logic                            busy,
  input  wire  [11:0]                     in_column,
  input  wire  [11:0]                     in_row,
  input  wire  [15:0]                     in_raw_depth,
  input  wire  [7:0]                      in_blue_in,
  input  wire  [7:0]                      in_green_in,
  input  wire  [7:0]                      in_red_in,
  // point output
  output logic                            out_valid,
  output logic signed [31:0]              out_world_x,
  output logic signed [31:0]              out_world_y,
  output logic signed [31:0]              out_world_z,
  output logic [7:0]                      out_red_out,
  output logic [7:0]                      out_green_out,
  output logic [7:0]                      out_blue_out,
  // configuration
  input  wire                             cfg_we,
  input  wire  [dpw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [63:0]                     cfg_data
);

  localparam int LN  = dpw_pkg::LANES;
  localparam int DW  = dpw_pkg::DIV_W;
  localparam int FW  = dpw_pkg::FRAC_W;
  localparam int NW  = dpw_pkg::NUM_W;
  localparam int TL  = dpw_pkg::TOTAL_LAT;

  localparam logic signed [35:0] ROT_ONE = 36'sh0_1000_0000;   // 1.0 in Q.28
  localparam logic signed [35:0] ROT_HI  = 36'sh0_2000_0000;   // +2.0
  localparam logic signed [35:0] ROT_LO  = 36'shF_E000_0000;   // -2.0
  localparam logic signed [36:0] SUM_MAX = 37'sh0_7FFF_FFFF;
  localparam logic signed [36:0] SUM_MIN = 37'sh1F_8000_0000;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] center_x_r;
  logic [15:0] center_y_r;
  logic [15:0] focal_x_r;
  logic [15:0] focal_y_r;
  logic [15:0] depth_scale_r;
  logic [63:0] pose_rot_r;
  logic [62:0] pose_trans_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= dpw_pkg::RST_CENTER_X;
      center_y_r    <= dpw_pkg::RST_CENTER_Y;
      focal_x_r     <= dpw_pkg::RST_FOCAL_X;
      focal_y_r     <= dpw_pkg::RST_FOCAL_Y;
      depth_scale_r <= dpw_pkg::RST_DEPTH_SCALE;
      pose_rot_r    <= dpw_pkg::RST_POSE_ROT;
      pose_trans_r  <= dpw_pkg::RST_POSE_TRANS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpw_pkg::REG_CENTER_X:    center_x_r    <= cfg_data[15:0];
        dpw_pkg::REG_CENTER_Y:    center_y_r    <= cfg_data[15:0];
        dpw_pkg::REG_FOCAL_X:     focal_x_r     <= cfg_data[15:0];
        dpw_pkg::REG_FOCAL_Y:     focal_y_r     <= cfg_data[15:0];
        dpw_pkg::REG_DEPTH_SCALE: depth_scale_r <= cfg_data[15:0];
        dpw_pkg::REG_POSE_ROT:    pose_rot_r    <= cfg_data;
        dpw_pkg::REG_POSE_TRANS:  pose_trans_r  <= cfg_data[62:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Quantities derived from configuration only. They are registered and
  // settle long before a newly taken pixel reaches them.
  // ---------------------------------------------------------------------
  logic [15:0]       fx_eff, fy_eff, sc_eff;
  dpw_pkg::divisor_t div_d_r [LN];

  assign fx_eff = (focal_x_r == '0)     ? 16'd1 : focal_x_r;
  assign fy_eff = (focal_y_r == '0)     ? 16'd1 : focal_y_r;
  assign sc_eff = (depth_scale_r == '0) ? 16'd1 : depth_scale_r;

  always_ff @(posedge clk) begin
    div_d_r[0] <= {16'd0, fx_eff} * {16'd0, sc_eff};
    div_d_r[1] <= {16'd0, fy_eff} * {16'd0, sc_eff};
    div_d_r[2] <= {16'd0, sc_eff};
  end

  // Quaternion products, then matrix entries in Q.28 clamped to [-2, 2]
  logic signed [31:0] qw, qx, qy, qz;
  logic signed [31:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic signed [35:0] ent   [LN][LN];
  dpw_pkg::rot_t      rot_r [LN][LN];

  assign qw = $signed({{16{pose_rot_r[63]}}, pose_rot_r[63:48]});
  assign qx = $signed({{16{pose_rot_r[47]}}, pose_rot_r[47:32]});
  assign qy = $signed({{16{pose_rot_r[31]}}, pose_rot_r[31:16]});
  assign qz = $signed({{16{pose_rot_r[15]}}, pose_rot_r[15:0]});

  always_ff @(posedge clk) begin
    xx_r <= qx * qx;
    yy_r <= qy * qy;
    zz_r <= qz * qz;
    xy_r <= qx * qy;
    xz_r <= qx * qz;
    yz_r <= qy * qz;
    wx_r <= qw * qx;
    wy_r <= qw * qy;
    wz_r <= qw * qz;
  end

  function automatic logic signed [35:0] sx36(input logic signed [31:0] a);
    sx36 = $signed({{4{a[31]}}, a});
  endfunction

  always_comb begin
    ent[0][0] = ROT_ONE - ((sx36(yy_r) + sx36(zz_r)) <<< 1);
    ent[0][1] = (sx36(xy_r) - sx36(wz_r)) <<< 1;
    ent[0][2] = (sx36(xz_r) + sx36(wy_r)) <<< 1;
    ent[1][0] = (sx36(xy_r) + sx36(wz_r)) <<< 1;
    ent[1][1] = ROT_ONE - ((sx36(xx_r) + sx36(zz_r)) <<< 1);
    ent[1][2] = (sx36(yz_r) - sx36(wx_r)) <<< 1;
    ent[2][0] = (sx36(xz_r) - sx36(wy_r)) <<< 1;
    ent[2][1] = (sx36(yz_r) + sx36(wx_r)) <<< 1;
    ent[2][2] = ROT_ONE - ((sx36(xx_r) + sx36(yy_r)) <<< 1);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LN; i++) begin
      for (int j = 0; j < LN; j++) begin
        if (ent[i][j] > ROT_HI) begin
          rot_r[i][j] <= ROT_HI[30:0];
        end else if (ent[i][j] < ROT_LO) begin
          rot_r[i][j] <= ROT_LO[30:0];
        end else begin
          rot_r[i][j] <= ent[i][j][30:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Front end: take the pixel, form |numerator| and its sign per lane.
  // Lane 0 is x, lane 1 is y, lane 2 is z.
  // ---------------------------------------------------------------------
  logic               f1_vld_r, f2_vld_r, f3_vld_r, f4_vld_r;
  logic signed [16:0] f1_dx_r, f1_dy_r;
  logic [15:0]        f1_depth_r;
  logic signed [33:0] prod_x_full, prod_y_full;
  logic signed [32:0] f2_prod_r [LN];
  logic signed [32:0] mag_full  [LN];
  logic               f3_neg_r  [LN];
  logic [DW-1:0]      f3_mag_r  [LN];
  logic               f4_neg_r  [LN];
  dpw_pkg::num_t      f4_num_r  [LN];
  logic [23:0]        pix_r     [TL];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
      f3_vld_r <= 1'b0;
      f4_vld_r <= 1'b0;
    end else begin
      // drop pixels without a depth measurement right at the input
      f1_vld_r <= start && !busy && (in_raw_depth != '0);
      f2_vld_r <= f1_vld_r;
      f3_vld_r <= f2_vld_r;
      f4_vld_r <= f3_vld_r;
    end
  end

  // Pixel offsets from the principal point in 1/16 pixel
  always_ff @(posedge clk) begin
    f1_dx_r    <= $signed({1'b0, in_column, 4'b0000}) - $signed({1'b0, center_x_r});
    f1_dy_r    <= $signed({1'b0, in_row, 4'b0000}) - $signed({1'b0, center_y_r});
    f1_depth_r <= in_raw_depth;
  end

  assign prod_x_full = $signed({{17{f1_dx_r[16]}}, f1_dx_r}) * $signed({18'd0, f1_depth_r});
  assign prod_y_full = $signed({{17{f1_dy_r[16]}}, f1_dy_r}) * $signed({18'd0, f1_depth_r});

  // |offset * depth| stays below 2^32, so 33 signed bits hold it
  always_ff @(posedge clk) begin
    f2_prod_r[0] <= prod_x_full[32:0];
    f2_prod_r[1] <= prod_y_full[32:0];
    f2_prod_r[2] <= $signed({17'd0, f1_depth_r});
  end

  always_comb begin
    for (int i = 0; i < LN; i++) begin
      mag_full[i] = f2_prod_r[i][32] ? -f2_prod_r[i] : f2_prod_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LN; i++) begin
      f3_neg_r[i] <= f2_prod_r[i][32];
      f3_mag_r[i] <= mag_full[i][DW-1:0];
    end
  end

  // Scale to Q.16 and add half the divisor for round-half-away-from-zero
  always_ff @(posedge clk) begin
    for (int i = 0; i < LN; i++) begin
      f4_neg_r[i] <= f3_neg_r[i];
      f4_num_r[i] <= {1'b0, f3_mag_r[i], {FW{1'b0}}}
                   + {{(NW-DW+1){1'b0}}, div_d_r[i][DW-1:1]};
    end
  end

  // Colour travels alongside in a shift line, reordered to red, green, blue
  always_ff @(posedge clk) begin
    pix_r[0] <= {in_red_in, in_green_in, in_blue_in};
    for (int k = 1; k < TL; k++) begin
      pix_r[k] <= pix_r[k-1];
    end
  end

  // ---------------------------------------------------------------------
  // Camera coordinates: one divider pipeline per lane
  // ---------------------------------------------------------------------
  logic          div_vld  [LN];
  dpw_pkg::cam_t div_quot [LN];
  logic          m0_vld;

  for (genvar i = 0; i < LN; i++) begin : g_lane
    dpw_pkg::div_ctl_t ctl;

    assign ctl.valid = f4_vld_r;
    assign ctl.neg   = f4_neg_r[i];

    dpw_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_ctl    (ctl),
      .in_num    (f4_num_r[i]),
      .divisor   (div_d_r[i]),
      .out_valid (div_vld[i]),
      .out_quot  (div_quot[i])
    );
  end

  assign m0_vld = div_vld[0] & div_vld[1] & div_vld[2];

  // ---------------------------------------------------------------------
  // Back end: rotate, round Q.44 to Q.16, add translation, saturate
  // ---------------------------------------------------------------------
  logic               m1_vld_r, m2_vld_r, m3_vld_r, out_valid_r;
  logic signed [62:0] m1_prod_r [LN][LN];
  logic signed [63:0] m2_acc_r  [LN];
  logic signed [63:0] biased    [LN];
  logic signed [35:0] m3_rnd_r  [LN];
  logic signed [20:0] trans     [LN];
  logic signed [36:0] wsum      [LN];
  dpw_pkg::cam_t      world_nxt [LN];
  dpw_pkg::cam_t      world_r   [LN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r    <= 1'b0;
      m2_vld_r    <= 1'b0;
      m3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      m1_vld_r    <= m0_vld;
      m2_vld_r    <= m1_vld_r;
      m3_vld_r    <= m2_vld_r;
      out_valid_r <= m3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LN; i++) begin
      for (int j = 0; j < LN; j++) begin
        m1_prod_r[i][j] <= $signed({{32{rot_r[i][j][30]}}, rot_r[i][j]})
                         * $signed({{31{div_quot[j][31]}}, div_quot[j]});
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LN; i++) begin
      m2_acc_r[i] <= $signed({m1_prod_r[i][0][62], m1_prod_r[i][0]})
                   + $signed({m1_prod_r[i][1][62], m1_prod_r[i][1]})
                   + $signed({m1_prod_r[i][2][62], m1_prod_r[i][2]});
    end
  end

  // Ties away from zero: a negative sum takes half minus one ulp
  always_comb begin
    for (int i = 0; i < LN; i++) begin
      biased[i] = m2_acc_r[i] + (m2_acc_r[i][63] ? 64'sh07FF_FFFF : 64'sh0800_0000);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LN; i++) begin
      m3_rnd_r[i] <= biased[i][63:28];
    end
  end

  assign trans[0] = $signed(pose_trans_r[62:42]);
  assign trans[1] = $signed(pose_trans_r[41:21]);
  assign trans[2] = $signed(pose_trans_r[20:0]);

  // Q10.10 translation moves to Q.16 by a shift of six
  always_comb begin
    for (int i = 0; i < LN; i++) begin
      wsum[i] = $signed({m3_rnd_r[i][35], m3_rnd_r[i]})
              + $signed({{10{trans[i][20]}}, trans[i], 6'b000000});
      if (wsum[i] > SUM_MAX) begin
        world_nxt[i] = dpw_pkg::CAM_MAX;
      end else if (wsum[i] < SUM_MIN) begin
        world_nxt[i] = dpw_pkg::CAM_MIN;
      end else begin
        world_nxt[i] = wsum[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LN; i++) begin
      world_r[i] <= world_nxt[i];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_world_x   = world_r[0];
  assign out_world_y   = world_r[1];
  assign out_world_z   = world_r[2];
  assign out_red_out   = pix_r[TL-1][23:16];
  assign out_green_out = pix_r[TL-1][15:8];
  assign out_blue_out  = pix_r[TL-1][7:0];

  `DPW_ASSERT_NOW(a_out_from_pixel, clk, rst_n, out_valid, $past(start && !busy && in_raw_depth != '0, dpw_pkg::TOTAL_LAT))
  `DPW_ASSERT_NOW(a_out_colour, clk, rst_n, out_valid, out_red_out == $past(in_red_in, dpw_pkg::TOTAL_LAT) && out_blue_out == $past(in_blue_in, dpw_pkg::TOTAL_LAT))
  `DPW_ASSERT_NOW(a_lanes_in_step, clk, rst_n, div_vld[0], div_vld[1] && div_vld[2])

endmodule

`default_nettype wire

// ----- src/dpw_div.sv -----
`default_nettype none
`include "assert_macros.svh"

// Pipelined restoring divider, one quotient bit per bit stage.
// Takes a magnitude numerator with the rounding half already added, returns
// the signed quotient saturated to 32 bits. Divisor must hold while words
// are in flight.
module dpw_div (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire dpw_pkg::div_ctl_t in_ctl,
  input  wire dpw_pkg::num_t     in_num,
  input  wire dpw_pkg::divisor_t divisor,
  output logic                  out_valid,
  output dpw_pkg::cam_t         out_quot
);

  localparam int DW = dpw_pkg::DIV_W;
  localparam int NW = dpw_pkg::NUM_W;

  logic          vld_r [0:DW];
  logic          neg_r [0:DW];
  logic          ovf_r [0:DW];
  logic [DW-1:0] rem_r [0:DW];
  logic [DW-1:0] lq_r  [0:DW];

  logic [DW-1:0] top_bits;
  logic          big;
  dpw_pkg::cam_t quot_nxt;
  logic          out_valid_r;
  dpw_pkg::cam_t out_quot_r;

  assign top_bits = {{(2*DW-NW){1'b0}}, in_num[NW-1:DW]};

  // Entry stage: flag quotients that do not fit in DW bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    neg_r[0] <= in_ctl.neg;
    ovf_r[0] <= (top_bits >= divisor);
    rem_r[0] <= top_bits;
    lq_r[0]  <= in_num[DW-1:0];
  end

  // Bit stages: shift a numerator bit into the remainder, subtract if it fits
  for (genvar k = 1; k <= DW; k++) begin : g_step
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;
    logic [DW-1:0] rem_nxt;
    logic [DW-1:0] lq_nxt;

    always_comb begin
      trial   = {rem_r[k-1], lq_r[k-1][DW-1]};
      diff    = trial - {1'b0, divisor};
      fits    = (trial >= {1'b0, divisor});
      rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];
      lq_nxt  = {lq_r[k-1][DW-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      neg_r[k] <= neg_r[k-1];
      ovf_r[k] <= ovf_r[k-1];
      rem_r[k] <= rem_nxt;
      lq_r[k]  <= lq_nxt;
    end
  end

  // Apply sign and saturate
  always_comb begin
    big = ovf_r[DW] || lq_r[DW][DW-1];
    if (big) begin
      quot_nxt = neg_r[DW] ? dpw_pkg::CAM_MIN : dpw_pkg::CAM_MAX;
    end else if (neg_r[DW]) begin
      quot_nxt = -$signed(lq_r[DW]);
    end else begin
      quot_nxt = $signed(lq_r[DW]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[DW];
    end
  end

  always_ff @(posedge clk) begin
    out_quot_r <= quot_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_quot  = out_quot_r;

  `DPW_ASSERT_NOW(a_div_latency, clk, rst_n, out_valid, $past(in_ctl.valid, dpw_pkg::DIV_LAT))
  `DPW_ASSERT_NEXT(a_div_ovf_sat, clk, rst_n, vld_r[DW] && ovf_r[DW], out_quot == dpw_pkg::CAM_MAX || out_quot == dpw_pkg::CAM_MIN)
  `DPW_ASSERT_NEXT(a_div_valid_out, clk, rst_n, vld_r[DW], out_valid)

endmodule

`default_nettype wire
